@@ rtl/ierp_pkg.sv @@
`timescale 1ns / 1ps
package ierp_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int TIME_BITS = 32;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SLOT_BITS-1:0] t_slot;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_VIS     = 3'd1,
        OP_ACTIVE  = 3'd2,
        OP_OPEN    = 3'd3,
        OP_SUSPREQ = 3'd4,
        OP_FREE    = 3'd5,
        OP_RESTART = 3'd6,
        OP_COLLECT = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SUSPEND = 2'd1,
        ACT_DESTROY = 2'd2
    } t_action;

    localparam logic [1:0] CFG_SUSPEND = 2'd0;
    localparam logic [1:0] CFG_DESTROY = 2'd1;
    localparam logic [1:0] CFG_CAP     = 2'd2;

    // age of an entry, clamped to zero when now is before the stamp
    function automatic t_time age_of(t_time now, t_time since);
        age_of = (now >= since) ? (now - since) : '0;
    endfunction
endpackage

@@ rtl/idle_entry_reclaim_policy_unit.sv @@
`timescale 1ns / 1ps
// channel   | dir | fields (low bit up)
// s_axis    | in  | tdata: operation[2:0] slot[6:3] flag[7] now[39:8]
// m_axis    | out | tdata: action[1:0] target_slot[5:2], tlast: last
// cfg       | in  | i_cfg_we, i_cfg_idx (0 suspend, 1 destroy, 2 cap), i_cfg_data
// events: accept, then one slot write or a sweep of all slots
// collect: one slot per cycle through one shared age/compare unit while the output register
//   is free: an aged pass over all slots, one oldest-pick scan, then one emit and one more
//   pick scan per excess destroy, a suspend pass over all slots, then the closing word
// a stalled output register holds the sequencer outside the pick scan for as long as it stalls
// reset is synchronous active low
module idle_entry_reclaim_policy_unit
    import ierp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // operation, slot, flag, now
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // action, target_slot, zero pad
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_AGED, S_PICK, S_SUSP, S_NONE} t_state;

    t_state r_state;
    t_time  r_susp_after, r_dest_after;
    logic [4:0] r_cap;

    logic [SLOTS-1:0] r_valid, r_pinned, r_vis, r_open, r_asked;
    t_time r_since [SLOTS];

    t_op   r_op;
    t_slot r_slot;
    logic  r_flag;
    t_time r_now;

    logic [SLOTS-1:0] r_reclaim, r_dest;
    logic [SLOT_BITS:0] r_nrec, r_idx;
    logic        r_found;
    t_slot       r_best;
    t_time       r_best_t;
    logic        r_any;

    // newest word is held back until the next one shows up or the collect ends,
    // so the final word can carry tlast
    t_action     r_hact;
    t_slot       r_hslot;

    // pending word: waits in output register
    logic        r_ovalid;
    t_action     r_oact;
    t_slot       r_oslot;
    logic        r_olast;

    t_slot w_i;
    t_time w_age, w_since;
    logic  w_out_free;
    logic  w_hidden;

    assign w_i        = r_idx[SLOT_BITS-1:0];
    assign w_since    = r_since[w_i];
    assign w_age      = age_of(r_now, w_since);
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_hidden   = r_valid[w_i] && !r_vis[w_i];

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oslot, r_oact};
    assign m_axis_tlast  = r_olast;

    // suspend due for the slot under the scan
    logic w_susp_due;
    assign w_susp_due = w_hidden && !r_dest[w_i] && !r_asked[w_i]
                        && (w_age >= r_susp_after);

    // new action found this cycle, or the closing word of a collect
    logic    w_gen;
    t_action w_gen_act;
    t_slot   w_gen_slot;
    logic    w_fin;

    always_comb begin
        w_gen      = 1'b0;
        w_gen_act  = ACT_DESTROY;
        w_gen_slot = w_i;
        w_fin      = 1'b0;
        if (w_out_free) begin
            case (r_state)
                S_AGED: begin
                    if (r_op == OP_COLLECT && w_hidden && !r_pinned[w_i] && !r_open[w_i]
                        && (w_age >= r_dest_after))
                        w_gen = 1'b1;
                end
                S_SUSP: begin
                    if (r_nrec > r_cap && r_idx == '0) begin
                        w_gen      = r_found;
                        w_gen_slot = r_best;
                    end else if (w_susp_due) begin
                        w_gen     = 1'b1;
                        w_gen_act = ACT_SUSPEND;
                    end
                end
                S_NONE: w_fin = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_any <= 1'b0;
            r_susp_after <= 32'd30000; r_dest_after <= 32'd300000; r_cap <= 5'd4;
            r_valid <= '0; r_pinned <= '0; r_vis <= '0; r_open <= '0; r_asked <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SUSPEND: r_susp_after <= i_cfg_data;
                    CFG_DESTROY: r_dest_after <= i_cfg_data;
                    CFG_CAP:     r_cap        <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op   <= t_op'(s_axis_tdata[2:0]);
                        r_slot <= s_axis_tdata[6:3];
                        r_flag <= s_axis_tdata[7];
                        r_now  <= s_axis_tdata[39:8];
                        r_idx  <= '0; r_nrec <= '0; r_any <= 1'b0;
                        r_reclaim <= '0; r_dest <= '0;
                        r_state <= S_AGED;
                    end
                end
                S_AGED: begin
                    if (r_op != OP_COLLECT) begin
                        // single-slot or sweep update, then back to idle
                        r_state <= S_IDLE;
                        for (int k = 0; k < SLOTS; k++) begin
                            if (r_op == OP_RESTART && r_valid[k]) begin
                                r_asked[k] <= 1'b0;
                                if (!r_vis[k]) r_since[k] <= r_now;
                            end
                        end
                        if (r_op == OP_CREATE) begin
                            r_valid[r_slot] <= 1'b1; r_pinned[r_slot] <= r_flag;
                            r_vis[r_slot] <= 1'b0; r_open[r_slot] <= 1'b0;
                            r_asked[r_slot] <= 1'b0; r_since[r_slot] <= r_now;
                        end else if (r_valid[r_slot]) begin
                            case (r_op)
                                OP_VIS: if (r_vis[r_slot] != r_flag) begin
                                    r_vis[r_slot] <= r_flag; r_asked[r_slot] <= 1'b0;
                                    if (!r_flag) r_since[r_slot] <= r_now;
                                end
                                OP_ACTIVE: begin
                                    r_asked[r_slot] <= 1'b0;
                                    if (!r_vis[r_slot]) r_since[r_slot] <= r_now;
                                end
                                OP_OPEN: if (r_open[r_slot] != r_flag) begin
                                    r_open[r_slot] <= r_flag;
                                    if (!r_flag && !r_vis[r_slot]) r_since[r_slot] <= r_now;
                                end
                                OP_SUSPREQ: r_asked[r_slot] <= 1'b1;
                                OP_FREE: begin
                                    r_valid[r_slot] <= 1'b0; r_pinned[r_slot] <= 1'b0;
                                    r_vis[r_slot] <= 1'b0; r_open[r_slot] <= 1'b0;
                                    r_asked[r_slot] <= 1'b0;
                                end
                                default: ;
                            endcase
                        end
                    end else if (w_out_free) begin
                        // aged pass over one slot
                        if (w_hidden && !r_pinned[w_i] && !r_open[w_i]) begin
                            if (w_age >= r_dest_after) begin
                                r_dest[w_i] <= 1'b1;
                            end else begin
                                r_reclaim[w_i] <= 1'b1;
                                r_nrec <= r_nrec + 1'b1;
                            end
                        end
                        if (r_idx == (SLOT_BITS+1)'(SLOTS-1)) begin
                            r_idx <= '0; r_found <= 1'b0;
                            r_state <= S_PICK;
                        end else r_idx <= r_idx + 1'b1;
                    end
                end
                S_PICK: begin
                    // oldest reclaimable entry, lower slot wins a tie
                    if (r_reclaim[w_i] && (!r_found || w_since < r_best_t)) begin
                        r_found <= 1'b1; r_best <= w_i; r_best_t <= w_since;
                    end
                    if (r_idx == (SLOT_BITS+1)'(SLOTS-1)) begin
                        r_idx <= '0;
                        r_state <= S_SUSP;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_SUSP: begin
                    if (r_nrec > r_cap && r_idx == '0) begin
                        // emit the picked entry, then search again
                        if (w_out_free) begin
                            if (r_found) begin
                                r_reclaim[r_best] <= 1'b0; r_dest[r_best] <= 1'b1;
                                r_nrec <= r_nrec - 1'b1;
                                r_found <= 1'b0;
                                r_state <= S_PICK;
                            end else r_nrec <= '0;
                        end
                    end else if (w_out_free) begin
                        if (r_idx == (SLOT_BITS+1)'(SLOTS-1)) r_state <= S_NONE;
                        else r_idx <= r_idx + 1'b1;
                    end
                end
                S_NONE: begin
                    // closing word goes out below
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // output register: closing word, held word, or drain
            if (w_fin) begin
                r_ovalid <= 1'b1; r_olast <= 1'b1;
                r_oact   <= r_any ? r_hact : ACT_NONE;
                r_oslot  <= r_any ? r_hslot : '0;
            end else if (w_gen) begin
                r_ovalid <= r_any; r_oact <= r_hact; r_oslot <= r_hslot; r_olast <= 1'b0;
                r_hact   <= w_gen_act; r_hslot <= w_gen_slot; r_any <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // a stalled output word holds still
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast));

    // no input word while busy or while a word waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE || m_axis_tvalid) |-> !s_axis_tready);

    // only defined actions, zero pad
    a_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ACT_NONE || m_axis_tdata[1:0] == ACT_SUSPEND
            || m_axis_tdata[1:0] == ACT_DESTROY) && m_axis_tdata[7:6] == 2'b00);

    // reclaim count stays within the table
    a_nrec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_nrec <= (SLOT_BITS+1)'(SLOTS));
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import ierp_pkg::*;

    // expected reclaim actions, checked against the output stream in order
    class reclaim_scoreboard;
        logic [31:0] suspend_after;
        logic [31:0] destroy_after;
        logic [4:0]  cap;
        bit          valid [SLOTS];
        bit          pinned [SLOTS];
        bit          visible [SLOTS];
        bit          opened [SLOTS];
        bit          asked [SLOTS];
        t_time       since [SLOTS];
        t_action     exp_act [$];
        t_slot       exp_slot [$];
        bit          exp_last [$];
        int          errors;

        function new();
            suspend_after = 30000;
            destroy_after = 300000;
            cap = 4;
            errors = 0;
            foreach (valid[i]) begin
                valid[i] = 0; pinned[i] = 0; visible[i] = 0;
                opened[i] = 0; asked[i] = 0; since[i] = '0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_SUSPEND) suspend_after = val;
            else if (idx == CFG_DESTROY) destroy_after = val;
            else if (idx == CFG_CAP) cap = val[4:0];
        endfunction

        function t_time hidden_age(int s, t_time now);
            return (now >= since[s]) ? now - since[s] : '0;
        endfunction

        function void push(t_action a, int s);
            exp_act  = {exp_act, a};
            exp_slot = {exp_slot, t_slot'(s)};
            exp_last = {exp_last, 1'b0};
        endfunction

        // sweep the table as a collect would and queue the actions
        function void predict_collect(t_time now);
            bit gone [SLOTS];
            bit spare [SLOTS];
            int nspare;
            int best;
            int n0;
            n0 = exp_act.size();
            nspare = 0;
            for (int s = 0; s < SLOTS; s++) begin
                gone[s] = 0; spare[s] = 0;
                if (!valid[s] || visible[s] || pinned[s] || opened[s]) continue;
                if (hidden_age(s, now) >= destroy_after) begin
                    gone[s] = 1;
                    push(ACT_DESTROY, s);
                end else begin
                    spare[s] = 1;
                    nspare++;
                end
            end
            // oldest first over the cap, lower slot wins a tie
            while (nspare > cap) begin
                best = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (spare[s] && (best < 0 || since[s] < since[best])) best = s;
                spare[best] = 0;
                gone[best] = 1;
                push(ACT_DESTROY, best);
                nspare--;
            end
            for (int s = 0; s < SLOTS; s++) begin
                if (!valid[s] || visible[s] || gone[s] || asked[s]) continue;
                if (hidden_age(s, now) >= suspend_after) push(ACT_SUSPEND, s);
            end
            if (exp_act.size() == n0) push(ACT_NONE, 0);
            exp_last[exp_last.size() - 1] = 1;
        endfunction

        // note an accepted input word
        function void note_input(t_op op, t_slot sl, bit flag, t_time now);
            int s;
            s = sl;
            if (op == OP_COLLECT) begin
                predict_collect(now);
                return;
            end
            if (op == OP_RESTART) begin
                for (int i = 0; i < SLOTS; i++)
                    if (valid[i]) begin
                        asked[i] = 0;
                        if (!visible[i]) since[i] = now;
                    end
                return;
            end
            if (op == OP_CREATE) begin
                valid[s] = 1; pinned[s] = flag; visible[s] = 0;
                opened[s] = 0; asked[s] = 0; since[s] = now;
                return;
            end
            if (!valid[s]) return;
            case (op)
                OP_VIS: if (visible[s] != flag) begin
                    visible[s] = flag;
                    asked[s] = 0;
                    if (!flag) since[s] = now;
                end
                OP_ACTIVE: begin
                    asked[s] = 0;
                    if (!visible[s]) since[s] = now;
                end
                OP_OPEN: if (opened[s] != flag) begin
                    opened[s] = flag;
                    if (!flag && !visible[s]) since[s] = now;
                end
                OP_SUSPREQ: asked[s] = 1;
                OP_FREE: begin
                    valid[s] = 0; pinned[s] = 0; visible[s] = 0;
                    opened[s] = 0; asked[s] = 0;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // check one accepted output word
        task check_result(logic [7:0] data, logic last);
            if (exp_act.size() == 0) begin
                report($sformatf("unexpected word %h", data));
                return;
            end
            if (data[1:0] !== exp_act[0])
                report($sformatf("action %0d, want %0d", data[1:0], exp_act[0]));
            if (data[5:2] !== exp_slot[0])
                report($sformatf("slot %0d, want %0d", data[5:2], exp_slot[0]));
            if (last !== exp_last[0])
                report($sformatf("last %0b, want %0b", last, exp_last[0]));
            void'(exp_act.pop_front());
            void'(exp_slot.pop_front());
            void'(exp_last.pop_front());
        endtask

        function int pending();
            return exp_act.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;      // operation, slot, flag, now
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;      // action, target_slot, zero pad
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    reclaim_scoreboard sb;
    int  hold_reqs = 0;     // long receiver hold-offs requested
    int  holds_done = 0;    // long receiver hold-offs served
    int  quiet_cycles = 0;
    t_time clock_now;   // rolling time base for random words

    idle_entry_reclaim_policy_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: score every accepted word
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);

    // receiver: random stalls per word, plus one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_reqs != holds_done) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                holds_done++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    // send one word; the handshake completes at the edge this returns on
    task automatic send_word(t_op op, t_slot sl, bit flag, t_time now, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {now, flag, sl, op};
        @(posedge i_clk iff s_axis_tready);
        sb.note_input(op, sl, flag, now);
    endtask

    task automatic send_idle(t_op op, t_slot sl, bit flag, t_time now);
        send_word(op, sl, flag, now, 0);
        s_axis_tvalid <= 0;
    endtask

    // wait out every expected word, then the collect pipeline tail
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk iff sb.pending() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_phase(int count, int span);
        t_op   op;
        int    r;
        int    gap;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 22) op = OP_CREATE;
            else if (r < 80) op = t_op'($urandom_range(1, 5));
            else if (r < 84) op = OP_RESTART;
            else op = OP_COLLECT;
            clock_now += $urandom_range(0, span);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            send_word(op, t_slot'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 19) == 0) ? t_time'($urandom) : clock_now, gap);
            // keep hold-off requests well inside the run
            if (n == count / 2 && count > 20) hold_reqs++;
        end
        drain();
    endtask

    initial begin
        sb = new();
        clock_now = 1000;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_SUSPEND;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, then a populated one at extreme times
        send_word(OP_COLLECT, 4'd0, 1'b0, '0, 0);
        send_word(OP_VIS, 4'd3, 1'b1, 32'd5, 0);         // empty slot, ignored
        send_word(OP_CREATE, 4'd0, 1'b0, 32'd0, 0);
        send_word(OP_CREATE, 4'd15, 1'b1, 32'hFFFF_FFFF, 0);
        send_word(OP_CREATE, 4'd5, 1'b0, 32'd100, 0);
        send_word(OP_CREATE, 4'd6, 1'b0, 32'd100, 0);    // tie with slot 5
        send_word(OP_CREATE, 4'd7, 1'b0, 32'd50, 0);
        send_word(OP_CREATE, 4'd8, 1'b0, 32'd60, 0);
        send_word(OP_CREATE, 4'd9, 1'b0, 32'd70, 0);
        send_word(OP_VIS, 4'd0, 1'b0, 32'd1, 0);         // same value, ignored
        send_word(OP_OPEN, 4'd5, 1'b1, 32'd1, 0);
        send_word(OP_OPEN, 4'd5, 1'b0, 32'd200, 0);
        send_word(OP_VIS, 4'd6, 1'b1, 32'd10, 0);
        send_word(OP_VIS, 4'd6, 1'b0, 32'd90, 0);
        send_word(OP_SUSPREQ, 4'd9, 1'b0, 32'd0, 0);
        send_word(OP_ACTIVE, 4'd8, 1'b0, 32'd40, 0);
        send_word(OP_COLLECT, 4'd0, 1'b0, 32'd20, 0);    // now before stamps
        send_word(OP_COLLECT, 4'd0, 1'b0, 32'd400000, 0);
        send_word(OP_FREE, 4'd7, 1'b0, 32'd0, 0);
        send_word(OP_RESTART, 4'd2, 1'b0, 32'd1000, 0);
        send_word(OP_COLLECT, 4'd0, 1'b0, 32'hFFFF_FFFF, 0);
        drain();

        // extreme settings: everything due at once, cap zero
        write_reg(CFG_SUSPEND, 32'd0);
        write_reg(CFG_DESTROY, 32'hFFFF_FFFF);
        write_reg(CFG_CAP, 32'd0);
        for (int s = 0; s < SLOTS; s++)
            send_word(OP_CREATE, t_slot'(s), s[0], t_time'(s * 3 % 7), 0);
        send_idle(OP_COLLECT, 4'd0, 1'b0, 32'd10);
        drain();

        // back-pressure: hold the receiver while words keep coming
        hold_reqs++;
        for (int n = 0; n < 6; n++)
            send_word(OP_COLLECT, 4'd0, 1'b0, t_time'(n * 1000), 0);
        drain();

        write_reg(CFG_CAP, 32'd16);
        write_reg(CFG_DESTROY, 32'd0);
        send_idle(OP_COLLECT, 4'd0, 1'b0, 32'd0);
        drain();

        // random phases over several settings
        write_reg(CFG_SUSPEND, 32'd3000);
        write_reg(CFG_DESTROY, 32'd20000);
        write_reg(CFG_CAP, 32'd3);
        random_phase(80, 800);

        write_reg(CFG_SUSPEND, 32'hFFFF_FFFF);
        write_reg(CFG_DESTROY, 32'd5000);
        write_reg(CFG_CAP, 32'd1);
        random_phase(70, 400);

        write_reg(CFG_SUSPEND, 32'd30000);
        write_reg(CFG_DESTROY, 32'd300000);
        write_reg(CFG_CAP, 32'd4);
        random_phase(60, 20000);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
